// ===== sv/rc_pulse_burst_command_decoder_top_defines.svh =====
// Assertion helpers used by the decoder top-level RTL.
`ifndef RC_PULSE_BURST_COMMAND_DECODER_TOP_DEFINES_SVH
`define RC_PULSE_BURST_COMMAND_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define RCPBD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rcpbd assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define RCPBD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rcpbd assertion failed");

`endif

// ===== sv/rcpbd_pkg.sv =====
package rcpbd_pkg;

    localparam int unsigned W_WIDTH = 12;
    localparam int unsigned W_MS    = 16;
    localparam int unsigned W_COUNT = 7;
    localparam int unsigned W_CIDX  = 3;

    localparam logic [W_WIDTH-1:0] A_EDGE_US  = 12'd1850;
    localparam logic [W_WIDTH-1:0] D_EDGE_US  = 12'd1150;
    localparam logic [W_WIDTH-1:0] C_EDGE_US  = 12'd1350;
    localparam logic [W_WIDTH-1:0] NB_EDGE_US = 12'd1550;
    localparam logic [W_WIDTH-1:0] NC_EDGE_US = 12'd1450;
    localparam logic [W_COUNT-1:0] COUNT_MAX  = 7'd127;

    localparam logic [W_CIDX-1:0] CFG_RESET_GAP   = 3'd0;
    localparam logic [W_CIDX-1:0] CFG_BURST_MIN   = 3'd1;
    localparam logic [W_CIDX-1:0] CFG_INTER_BURST = 3'd2;
    localparam logic [W_CIDX-1:0] CFG_RECALL_HOLD = 3'd3;
    localparam logic [W_CIDX-1:0] CFG_ABORT       = 3'd4;

    localparam logic [W_MS-1:0] RST_RESET_GAP   = 16'd1000;
    localparam logic [W_MS-1:0] RST_BURST_MIN   = 16'd250;
    localparam logic [W_MS-1:0] RST_INTER_BURST = 16'd250;
    localparam logic [W_MS-1:0] RST_RECALL_HOLD = 16'd1000;
    localparam logic [W_MS-1:0] RST_ABORT       = 16'd2000;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_REPEAT    = 3'd1,
        PH_BURST     = 3'd2,
        PH_WAIT_NEUT = 3'd3,
        PH_CONF_NEUT = 3'd4
    } t_phase;

    typedef struct packed {
        logic [W_MS-1:0] reset_gap_ms;
        logic [W_MS-1:0] burst_min_ms;
        logic [W_MS-1:0] inter_burst_ms;
        logic [W_MS-1:0] recall_hold_ms;
        logic [W_MS-1:0] abort_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic               hit;
        logic [W_COUNT-1:0] burst_count;
        logic               side_a;
        logic               is_repeat;
    } t_result;

endpackage

// ===== sv/rcpbd_in_if.sv =====
interface rcpbd_in_if;
    import rcpbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [W_WIDTH-1:0] pulse_width_us;
    logic [W_MS-1:0]    now_ms;

    modport source (output valid, output pulse_width_us, output now_ms, input ready);
    modport sink   (input valid, input pulse_width_us, input now_ms, output ready);
endinterface

// ===== sv/rcpbd_out_if.sv =====
interface rcpbd_out_if;
    import rcpbd_pkg::*;

    logic               valid;
    logic               ready;
    logic [W_COUNT-1:0] burst_count;
    logic               side_a;
    logic               is_repeat;

    modport source (output valid, output burst_count, output side_a, output is_repeat,
                    input ready);
    modport sink   (input valid, input burst_count, input side_a, input is_repeat,
                    output ready);
endinterface

// ===== sv/rcpbd_core.sv =====
module rcpbd_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [rcpbd_pkg::W_WIDTH-1:0]  i_width,
    input  logic [rcpbd_pkg::W_MS-1:0]     i_now,
    input  rcpbd_pkg::t_cfg                i_cfg,
    output rcpbd_pkg::t_result             o_res
);
    import rcpbd_pkg::*;

    t_phase             r_phase, n_phase;
    logic [W_MS-1:0]    r_start, n_start;
    logic [W_COUNT-1:0] r_count, n_count;
    logic               r_side_a, n_side_a;
    logic               r_rep_pend, n_rep_pend;
    logic               r_gap, n_gap;
    logic [7:0]         r_last, n_last;

    logic [W_MS-1:0] el, el_after;
    logic            band_a, band_d, band_c, band_neu, band_burst;
    logic [7:0]      cmd;
    logic            is_rep;

    assign el         = i_now - r_start;
    assign band_a     = i_width > A_EDGE_US;
    assign band_d     = i_width < D_EDGE_US;
    assign band_c     = (i_width > D_EDGE_US) && (i_width < C_EDGE_US);
    assign band_neu   = (i_width >= NC_EDGE_US) && (i_width <= NB_EDGE_US);
    assign band_burst = r_side_a ? band_a : band_d;

    always_comb begin
        n_phase    = r_phase;
        n_start    = r_start;
        n_count    = r_count;
        n_side_a   = r_side_a;
        n_rep_pend = r_rep_pend;
        n_gap      = r_gap;
        n_last     = r_last;
        cmd        = 8'd0;
        is_rep     = 1'b0;
        el_after   = el;
        unique case (r_phase)
            PH_IDLE: begin
                if (band_a || band_d) begin
                    n_start    = i_now;
                    n_count    = '0;
                    n_rep_pend = 1'b0;
                    n_gap      = 1'b0;
                    n_side_a   = band_a;
                    n_phase    = PH_BURST;
                end else if (band_c) begin
                    n_start = i_now;
                    n_phase = PH_REPEAT;
                end
            end
            PH_REPEAT: begin
                if (band_c) begin
                    if (el >= i_cfg.recall_hold_ms) begin
                        n_rep_pend = 1'b1;
                        n_phase    = PH_WAIT_NEUT;
                    end
                end else if (el >= i_cfg.abort_timeout_ms || band_d) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_BURST: begin
                if (band_burst) begin
                    if (el >= i_cfg.burst_min_ms) begin
                        if (r_count != COUNT_MAX) n_count = r_count + 1'b1;
                        n_phase = PH_WAIT_NEUT;
                    end
                end else if (el >= i_cfg.abort_timeout_ms) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_WAIT_NEUT: begin
                if (band_neu) begin
                    n_start = i_now;
                    n_phase = PH_CONF_NEUT;
                end else if (el >= i_cfg.abort_timeout_ms) begin
                    n_phase = PH_IDLE;
                end
            end
            PH_CONF_NEUT: begin
                if (band_neu) begin
                    if (el >= i_cfg.inter_burst_ms) begin
                        n_gap = 1'b1;
                        if (el >= i_cfg.reset_gap_ms) begin
                            if (r_rep_pend) begin
                                n_rep_pend = 1'b0;
                                cmd        = r_last;
                                is_rep     = 1'b1;
                            end else begin
                                cmd    = {r_side_a, r_count};
                                n_last = {r_side_a, r_count};
                            end
                            n_phase = PH_IDLE;
                        end
                    end
                end else begin
                    if (r_gap && band_burst) begin
                        n_gap    = 1'b0;
                        n_start  = i_now;
                        n_phase  = PH_BURST;
                        el_after = '0;
                    end
                    if (el_after >= i_cfg.abort_timeout_ms) n_phase = PH_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res.hit         = cmd != 8'd0;
        o_res.burst_count = cmd[W_COUNT-1:0];
        o_res.side_a      = cmd[7];
        o_res.is_repeat   = is_rep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_start    <= '0;
            r_count    <= '0;
            r_side_a   <= 1'b0;
            r_rep_pend <= 1'b0;
            r_gap      <= 1'b0;
            r_last     <= 8'd0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_start    <= n_start;
            r_count    <= n_count;
            r_side_a   <= n_side_a;
            r_rep_pend <= n_rep_pend;
            r_gap      <= n_gap;
            r_last     <= n_last;
        end
    end

endmodule

// ===== sv/rc_pulse_burst_command_decoder_top.sv =====
// A result is registered and seen on o_out in the cycle after its input transfer.
// One input item per cycle while i_in.ready is high; decode is one phase-logic pass.
// The output register lets a new input transfer proceed while a result is being taken.
// Reset (i_rst_n low, synchronous): phase idle, counters and flags cleared, no stored
// command, registers back to their defaults, output empty.
`include "rc_pulse_burst_command_decoder_top_defines.svh"

module rc_pulse_burst_command_decoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    rcpbd_in_if.sink                       i_in,
    rcpbd_out_if.source                    o_out,
    input  logic                           i_cfg_we,
    input  logic [rcpbd_pkg::W_CIDX-1:0]   i_cfg_index,
    input  logic [rcpbd_pkg::W_MS-1:0]     i_cfg_data
);
    import rcpbd_pkg::*;

    t_cfg               r_cfg;
    t_result            core_res;
    logic               accept;
    logic               r_out_valid;
    logic [W_COUNT-1:0] r_out_count;
    logic               r_out_side_a;
    logic               r_out_repeat;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_gap_ms     <= RST_RESET_GAP;
            r_cfg.burst_min_ms     <= RST_BURST_MIN;
            r_cfg.inter_burst_ms   <= RST_INTER_BURST;
            r_cfg.recall_hold_ms   <= RST_RECALL_HOLD;
            r_cfg.abort_timeout_ms <= RST_ABORT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RESET_GAP:   r_cfg.reset_gap_ms     <= i_cfg_data;
                CFG_BURST_MIN:   r_cfg.burst_min_ms     <= i_cfg_data;
                CFG_INTER_BURST: r_cfg.inter_burst_ms   <= i_cfg_data;
                CFG_RECALL_HOLD: r_cfg.recall_hold_ms   <= i_cfg_data;
                CFG_ABORT:       r_cfg.abort_timeout_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rcpbd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (accept),
        .i_width (i_in.pulse_width_us),
        .i_now   (i_in.now_ms),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= core_res.hit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && core_res.hit) begin
            r_out_count  <= core_res.burst_count;
            r_out_side_a <= core_res.side_a;
            r_out_repeat <= core_res.is_repeat;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.burst_count = r_out_count;
    assign o_out.side_a      = r_out_side_a;
    assign o_out.is_repeat   = r_out_repeat;

    `RCPBD_ASSERT_IMP(a_ready_when_empty, !r_out_valid, i_in.ready)
    `RCPBD_ASSERT_NXT(a_no_result_without_transfer,
        !accept && !(r_out_valid && !o_out.ready), !o_out.valid)
    `RCPBD_ASSERT_IMP(a_result_not_empty, o_out.valid,
        (o_out.burst_count != '0) || o_out.side_a)
    `RCPBD_ASSERT_NXT(a_result_loaded, accept && core_res.hit, o_out.valid)

endmodule
